FILE: src/kps_pkg.sv
// Package for the keep-alive ping supervisor: field widths, event codes
// and configuration register indexes. No dependencies.
`default_nettype none

package kps_pkg;

  // Fixed field and register widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned FAIL_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Event codes carried in the opcode field
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 2'd0,
    OP_CLIENT    = 2'd1,
    OP_PONG      = 2'd2,
    OP_SEND_FAIL = 2'd3
  } kps_op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PONG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd2;

  // Register values after reset
  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd15;
  localparam logic [TIMEOUT_W-1:0] PONG_TIMEOUT_RST = 16'd5;
  localparam logic [FAIL_W-1:0]    MAX_FAILURES_RST = 8'd3;

  localparam logic [FAIL_W-1:0]    FAIL_MAX = {FAIL_W{1'b1}};

endpackage

`default_nettype wire

FILE: src/kps_in_if.sv
// Event channel of the keep-alive supervisor: valid/ready plus event payload.
// Depends on kps_pkg.
`default_nettype none

interface kps_in_if;
  import kps_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                authenticated;

  modport source (output valid, output opcode, output authenticated, input ready);
  modport sink   (input valid, input opcode, input authenticated, output ready);
endinterface

`default_nettype wire

FILE: src/kps_out_if.sv
// Result channel of the keep-alive supervisor: valid/ready plus status payload.
// Depends on kps_pkg.
`default_nettype none

interface kps_out_if;
  import kps_pkg::*;

  logic              valid;
  logic              ready;
  logic              send_ping;
  logic              session_closed;
  logic [FAIL_W-1:0] failure_count;
  logic              awaiting_pong;

  modport source (output valid, output send_ping, output session_closed,
                  output failure_count, output awaiting_pong, input ready);
  modport sink   (input valid, input send_ping, input session_closed,
                  input failure_count, input awaiting_pong, output ready);
endinterface

`default_nettype wire

FILE: src/keepalive_ping_supervisor_unit.sv
// Keep-alive ping supervisor, top level: session state, timers and result register.
// Depends on kps_pkg, kps_in_if and kps_out_if.
//
// Usage:
//   in_beat carries one event per beat (tick, client message, pong, ping send
//   failure) with the authenticated flag. out_beat returns exactly one status
//   beat per event: send_ping, session_closed, failure_count, awaiting_pong.
//   cfg_we/cfg_index/cfg_data write idle_timeout (0), pong_timeout (1) and
//   max_failures (2); write only while no event is in flight.
// Output: the status beat is registered and valid in the cycle after acceptance.
// Throughput: one event per cycle unless stalled. The session state is updated
//   at the accepting edge, so the next event sees it at once; the only stored
//   stage is the result register.
// Stall: in_beat.ready drops only while a result is held and out_beat.ready is
//   low; a result taken in the same cycle frees the register for a new event.
// Reset (rst_n low, synchronous): session live, counters and missed count
//   zero, no ping outstanding, registers at 15 / 5 / 3, no result pending.
// A closed session ignores all events until reset.
`default_nettype none

module keepalive_ping_supervisor_unit #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [kps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [kps_pkg::CFG_DATA_W-1:0]    cfg_data,
  kps_in_if.sink                           in_beat,
  kps_out_if.source                        out_beat
);
  import kps_pkg::*;

  // Compare width: wide enough for both the timers and the timeout registers
  localparam int unsigned CW = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Configuration registers
  logic [TIMEOUT_W-1:0] idle_to_r;
  logic [TIMEOUT_W-1:0] pong_to_r;
  logic [FAIL_W-1:0]    max_fail_r;

  // Session state
  logic              live_r,    live_nxt;
  timer_t            idle_r,    idle_nxt;
  timer_t            pong_r,    pong_nxt;
  logic              wait_r,    wait_nxt;
  logic [FAIL_W-1:0] missed_r,  missed_nxt;
  logic              ping_nxt;

  // Result register
  logic              out_valid_r;
  logic              ping_r;
  logic              closed_r;
  logic [FAIL_W-1:0] fail_r;
  logic              await_r;

  logic    accept;
  kps_op_t op;

  // Tick helpers
  timer_t            idle_inc;
  timer_t            pong_inc;
  logic              ping_req;
  logic              wait_mid;
  timer_t            pong_mid;
  logic              miss;
  logic [FAIL_W-1:0] missed_inc;

  assign in_beat.ready = !out_valid_r || out_beat.ready;
  assign accept        = in_beat.valid && in_beat.ready;
  assign op            = kps_op_t'(in_beat.opcode);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_to_r  <= IDLE_TIMEOUT_RST;
      pong_to_r  <= PONG_TIMEOUT_RST;
      max_fail_r <= MAX_FAILURES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_to_r  <= cfg_data;
        CFG_PONG_TIMEOUT: pong_to_r  <= cfg_data;
        CFG_MAX_FAILURES: max_fail_r <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick datapath: advance, then ping check, then pong timeout check
  always_comb begin
    idle_inc   = (idle_r == '1) ? idle_r : idle_r + 1'b1;
    pong_inc   = (wait_r && pong_r != '1) ? pong_r + 1'b1 : pong_r;
    ping_req   = !wait_r && (CW'(idle_inc) >= CW'(idle_to_r));
    wait_mid   = wait_r || ping_req;
    pong_mid   = ping_req ? '0 : pong_inc;
    miss       = wait_mid && (CW'(pong_mid) >= CW'(pong_to_r));
    missed_inc = (missed_r == FAIL_MAX) ? missed_r : missed_r + 1'b1;
  end

  // Event decode and next session state
  always_comb begin
    live_nxt   = live_r;
    idle_nxt   = idle_r;
    pong_nxt   = pong_r;
    wait_nxt   = wait_r;
    missed_nxt = missed_r;
    ping_nxt   = 1'b0;
    if (live_r) begin
      unique case (op)
        OP_TICK: begin
          pong_nxt = pong_inc;
          idle_nxt = '0;
          if (in_beat.authenticated) begin
            ping_nxt = ping_req;
            pong_nxt = pong_mid;
            wait_nxt = wait_mid;
            idle_nxt = idle_inc;
            if (miss) begin
              missed_nxt = missed_inc;
              wait_nxt   = 1'b0;
              idle_nxt   = '0;
              if (missed_inc >= max_fail_r) live_nxt = 1'b0;
            end
          end
        end
        OP_CLIENT: idle_nxt = '0;
        OP_PONG: begin
          idle_nxt   = '0;
          pong_nxt   = '0;
          wait_nxt   = 1'b0;
          missed_nxt = '0;
        end
        OP_SEND_FAIL: live_nxt = 1'b0;
      endcase
    end
  end

  // Session state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= 1'b1;
      idle_r   <= '0;
      pong_r   <= '0;
      wait_r   <= 1'b0;
      missed_r <= '0;
    end else if (accept) begin
      live_r   <= live_nxt;
      idle_r   <= idle_nxt;
      pong_r   <= pong_nxt;
      wait_r   <= wait_nxt;
      missed_r <= missed_nxt;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ping_r   <= ping_nxt;
      closed_r <= !live_nxt;
      fail_r   <= missed_nxt;
      await_r  <= wait_nxt;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.send_ping      = ping_r;
  assign out_beat.session_closed = closed_r;
  assign out_beat.failure_count  = fail_r;
  assign out_beat.awaiting_pong  = await_r;

`ifndef ASSERT_OFF
  // A closed session stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !live_r |=> !live_r)
    else $error("session reopened without reset");

  // Every accepted event yields a pending result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted event produced no result");

  // Only a pong lowers the missed count
  a_missed_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op != OP_PONG) |=> (missed_r >= $past(missed_r)))
    else $error("missed count dropped without a pong");
`endif

endmodule

`default_nettype wire
